// ===== src/bdq_pkg.sv =====
// Package for the bounded deque: depth, derived widths, request kinds,
// status codes, ring arithmetic and the controller-to-datapath command struct.
// Depends on nothing; every other file but bdq_ram refers to it by scoped names.
package bdq_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int VAL_W     = 32;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int IN_DATA_W = ((VAL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } t_req;

    typedef logic [STAT_W-1:0] t_status;
    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic capture;   // latch the accepted item
        logic exec;      // update pointers and access the ring
        logic load_out;  // move the finished result into the output register
    } t_cmd;

    // Position base + offset on the ring; base < DEPTH and offset <= DEPTH.
    function automatic t_idx ring_add(input t_idx base, input t_cnt offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offset);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== src/bdq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the ring store of the deque.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(DEPTH)-1:0]       i_waddr,
    input  logic [WIDTH-1:0]               i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(DEPTH)-1:0]       i_raddr,
    output logic [WIDTH-1:0]               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bdq_ctrl.sv =====
// Controller of the bounded deque: sequences capture, execute and result load.
// Depends on bdq_pkg; drives the datapath only through a t_cmd struct.
module bdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output bdq_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                // The result waits here until the output register is free.
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == S_EXEC))
        else $error("accepted item did not move to execute");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> out_free)
        else $error("result loaded over an untaken result");

    a_exec_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == S_LOAD))
        else $error("execute not followed by result load state");

endmodule

// ===== src/bdq_dp.sv =====
// Datapath of the bounded deque: item latch, front pointer, count, ring
// store and output register. Depends on bdq_pkg and bdq_ram.
module bdq_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bdq_pkg::t_cmd                   i_cmd,
    input  logic [bdq_pkg::REQ_W-1:0]       i_req,
    input  logic [bdq_pkg::VAL_W-1:0]       i_value,
    output logic [bdq_pkg::OUT_DATA_W-1:0]  o_data,
    output logic [bdq_pkg::STAT_W-1:0]      o_user
);

    bdq_pkg::t_req    r_req;
    logic [bdq_pkg::VAL_W-1:0] r_value;
    bdq_pkg::t_idx    r_front, n_front;
    bdq_pkg::t_cnt    r_count, n_count;
    bdq_pkg::t_status r_status, n_status;
    logic             r_pop_ok, n_pop_ok;
    logic [bdq_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [bdq_pkg::STAT_W-1:0]     r_out_user;

    logic             full, empty;
    logic             ram_we, ram_re;
    bdq_pkg::t_idx    ram_waddr, ram_raddr;
    logic [bdq_pkg::VAL_W-1:0] ram_rdata;
    bdq_pkg::t_idx    front_dec, front_inc, back_pos, last_pos;

    assign full  = (r_count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
    assign empty = (r_count == '0);

    assign front_dec = bdq_pkg::ring_add(r_front, bdq_pkg::CNT_W'(bdq_pkg::DEPTH - 1));
    assign front_inc = bdq_pkg::ring_add(r_front, bdq_pkg::CNT_W'(1));
    assign back_pos  = bdq_pkg::ring_add(r_front, r_count);
    assign last_pos  = bdq_pkg::ring_add(r_front, r_count - bdq_pkg::CNT_W'(1));

    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_status  = bdq_pkg::STAT_OK;
        n_pop_ok  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = back_pos;
        ram_raddr = r_front;
        unique case (r_req)
            bdq_pkg::REQ_PUSH_FRONT: begin
                ram_waddr = front_dec;
                if (full) begin
                    n_status = bdq_pkg::STAT_FULL;
                end else begin
                    ram_we  = i_cmd.exec;
                    n_front = front_dec;
                    n_count = r_count + bdq_pkg::CNT_W'(1);
                end
            end
            bdq_pkg::REQ_PUSH_BACK: begin
                if (full) begin
                    n_status = bdq_pkg::STAT_FULL;
                end else begin
                    ram_we  = i_cmd.exec;
                    n_count = r_count + bdq_pkg::CNT_W'(1);
                end
            end
            bdq_pkg::REQ_POP_FRONT: begin
                if (empty) begin
                    n_status = bdq_pkg::STAT_EMPTY;
                end else begin
                    ram_re   = i_cmd.exec;
                    n_pop_ok = 1'b1;
                    n_front  = front_inc;
                    n_count  = r_count - bdq_pkg::CNT_W'(1);
                end
            end
            bdq_pkg::REQ_POP_BACK: begin
                ram_raddr = last_pos;
                if (empty) begin
                    n_status = bdq_pkg::STAT_EMPTY;
                end else begin
                    ram_re   = i_cmd.exec;
                    n_pop_ok = 1'b1;
                    n_count  = r_count - bdq_pkg::CNT_W'(1);
                end
            end
            default: begin
                n_status = bdq_pkg::STAT_OK;
            end
        endcase
    end

    bdq_ram #(
        .WIDTH (bdq_pkg::VAL_W),
        .DEPTH (bdq_pkg::DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= bdq_pkg::t_req'(i_req);
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
        // The read data stays put after execute since the RAM is read only then.
        if (i_cmd.load_out) begin
            r_out_data <= bdq_pkg::OUT_DATA_W'({r_count,
                          (r_pop_ok ? ram_rdata : {bdq_pkg::VAL_W{1'b0}})});
            r_out_user <= r_status;
        end
    end

    assign o_data = r_out_data;
    assign o_user = r_out_user;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
        else $error("occupancy beyond depth");

    a_count_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> (r_count == $past(r_count)))
        else $error("occupancy changed outside execute");

endmodule

// ===== src/bounded_deque.sv =====
// Top level of the bounded deque: a ring-store double-ended queue of signed
// 32-bit values. Depends on bdq_pkg, bdq_ctrl, bdq_dp and bdq_ram.
//
// Channel   Dir  Handshake                        Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: push_value; tuser: req_type
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: pop_value, occupancy; tuser: status
//
// An item goes through capture, execute (pointer and count update plus
// one ring RAM access) and result load, the last needed for the RAM's registered read.
// Reset clears the front pointer, the count and the control state;
// the ring RAM is not cleared and needs no clearing pass.
// A stalled result holds in the output register while the next item is
// captured and executed; that item then waits until the result is taken.
module bounded_deque (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [bdq_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,  // [31:0] push_value
    input  logic [bdq_pkg::REQ_W-1:0]       i_s_axis_tuser,  // [1:0] req_type
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [bdq_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,  // [31:0] pop_value,
                                                             // [36:32] occupancy, rest zero
    output logic [bdq_pkg::STAT_W-1:0]      o_m_axis_tuser   // [1:0] status
);

    bdq_pkg::t_cmd cmd;

    bdq_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_cmd           (cmd)
    );

    bdq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_s_axis_tuser),
        .i_value (i_s_axis_tdata[bdq_pkg::VAL_W-1:0]),
        .o_data  (o_m_axis_tdata),
        .o_user  (o_m_axis_tuser)
    );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for bounded_deque: drives push and pop requests on the input
// stream and checks every result against a deque predictor held in a scoreboard class.
// Depends on bdq_pkg and the bounded_deque RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int ITEMS_PER_PHASE = 444;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [bdq_pkg::VAL_W-1:0] pop_value;
        bdq_pkg::t_cnt             occupancy;
        bdq_pkg::t_status          status;
    } t_deque_result;

    // Keeps its own copy of the ring, the front position and the fill level, and a
    // queue of the results that the accepted requests must produce, oldest first.
    class deque_scoreboard;
        logic [bdq_pkg::VAL_W-1:0] ring [bdq_pkg::DEPTH];
        int                        head;
        int                        fill;
        t_deque_result             expected_q [$];
        int                        mismatches;

        function new();
            head = 0;
            fill = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(input bdq_pkg::t_req req,
                                   input logic [bdq_pkg::VAL_W-1:0] value);
            t_deque_result r;
            r.pop_value = '0;
            r.status    = bdq_pkg::STAT_OK;
            case (req)
                bdq_pkg::REQ_PUSH_FRONT: begin
                    if (fill >= bdq_pkg::DEPTH) begin
                        r.status = bdq_pkg::STAT_FULL;
                    end else begin
                        head = (head + bdq_pkg::DEPTH - 1) % bdq_pkg::DEPTH;
                        ring[head] = value;
                        fill++;
                    end
                end
                bdq_pkg::REQ_PUSH_BACK: begin
                    if (fill >= bdq_pkg::DEPTH) begin
                        r.status = bdq_pkg::STAT_FULL;
                    end else begin
                        ring[(head + fill) % bdq_pkg::DEPTH] = value;
                        fill++;
                    end
                end
                bdq_pkg::REQ_POP_FRONT: begin
                    if (fill == 0) begin
                        r.status = bdq_pkg::STAT_EMPTY;
                    end else begin
                        r.pop_value = ring[head];
                        head = (head + 1) % bdq_pkg::DEPTH;
                        fill--;
                    end
                end
                default: begin
                    if (fill == 0) begin
                        r.status = bdq_pkg::STAT_EMPTY;
                    end else begin
                        r.pop_value = ring[(head + fill - 1) % bdq_pkg::DEPTH];
                        fill--;
                    end
                end
            endcase
            r.occupancy = bdq_pkg::t_cnt'(fill);
            expected_q.push_back(r);
        endfunction

        function void check_result(input logic [bdq_pkg::OUT_DATA_W-1:0] tdata,
                                   input bdq_pkg::t_status tuser);
            t_deque_result exp_r;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result: value %h occupancy %0d status %0d",
                             tdata[bdq_pkg::VAL_W-1:0],
                             tdata[bdq_pkg::VAL_W+bdq_pkg::CNT_W-1:bdq_pkg::VAL_W], tuser);
                return;
            end
            exp_r = expected_q.pop_front();
            if (tdata[bdq_pkg::VAL_W-1:0] !== exp_r.pop_value
                    || tdata[bdq_pkg::VAL_W+bdq_pkg::CNT_W-1:bdq_pkg::VAL_W]
                       !== exp_r.occupancy
                    || tuser !== exp_r.status
                    || tdata[bdq_pkg::OUT_DATA_W-1:bdq_pkg::VAL_W+bdq_pkg::CNT_W] !== '0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: result mismatch: expected value %h occupancy %0d status %0d,",
                             exp_r.pop_value, exp_r.occupancy, exp_r.status);
                    $display("       got value %h occupancy %0d status %0d pad %h",
                             tdata[bdq_pkg::VAL_W-1:0],
                             tdata[bdq_pkg::VAL_W+bdq_pkg::CNT_W-1:bdq_pkg::VAL_W], tuser,
                             tdata[bdq_pkg::OUT_DATA_W-1:bdq_pkg::VAL_W+bdq_pkg::CNT_W]);
                end
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [bdq_pkg::IN_DATA_W-1:0]  i_s_axis_tdata = '0;   // [31:0] push_value
    logic [bdq_pkg::REQ_W-1:0]      i_s_axis_tuser = '0;   // [1:0] req_type
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [bdq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;  // [31:0] pop_value, [36:32] occupancy
    logic [bdq_pkg::STAT_W-1:0]     o_m_axis_tuser;  // [1:0] status

    deque_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_reqs = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int idle_cycles = 0;

    bounded_deque u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random, or holds off for a long stretch when asked.
    always @(negedge i_clk) begin
        if (rx_hold_reqs != rx_hold_seen) begin
            rx_hold_seen = rx_hold_reqs;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input bdq_pkg::t_req req,
                             input logic [bdq_pkg::VAL_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= $urandom;
            i_s_axis_tuser  <= bdq_pkg::REQ_W'($urandom);
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= bdq_pkg::IN_DATA_W'(value);
        i_s_axis_tuser  <= req;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(req, value);
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [bdq_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(15))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Bias 0 mostly pushes, bias 1 mostly pops, bias 2 mixes evenly, so the fill
    // level keeps swinging between empty and full.
    function automatic bdq_pkg::t_req pick_request(input int bias);
        int  roll;
        bit  is_push;
        roll = $urandom_range(99);
        is_push = (bias == 0) ? (roll < 80) : (bias == 1) ? (roll < 20) : (roll < 50);
        if (is_push)
            return $urandom_range(1) ? bdq_pkg::REQ_PUSH_BACK : bdq_pkg::REQ_PUSH_FRONT;
        return $urandom_range(1) ? bdq_pkg::REQ_POP_BACK : bdq_pkg::REQ_POP_FRONT;
    endfunction

    task automatic run_random(input int n_items);
        int sent;
        int bias;
        int burst_len;
        sent = 0;
        while (sent < n_items) begin
            bias = $urandom_range(2);
            burst_len = $urandom_range(40, 4);
            for (int k = 0; k < burst_len && sent < n_items; k++) begin
                send_item(pick_request(bias), pick_value());
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Pops on an empty queue, then the value extremes through both ends.
        send_item(bdq_pkg::REQ_POP_FRONT, $urandom);
        send_item(bdq_pkg::REQ_POP_BACK, $urandom);
        send_item(bdq_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFF);
        send_item(bdq_pkg::REQ_PUSH_BACK, 32'h8000_0000);
        send_item(bdq_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        send_item(bdq_pkg::REQ_PUSH_BACK, 32'h0000_0000);
        send_item(bdq_pkg::REQ_POP_BACK, $urandom);
        send_item(bdq_pkg::REQ_POP_FRONT, $urandom);
        // Fill to the top from both ends, wrapping the ring, then push into a full queue.
        for (int i = 0; i < bdq_pkg::DEPTH - 2; i++)
            send_item((i % 2) ? bdq_pkg::REQ_PUSH_BACK : bdq_pkg::REQ_PUSH_FRONT,
                      32'h1 << (i * 2));
        send_item(bdq_pkg::REQ_PUSH_FRONT, 32'hA5A5_A5A5);
        send_item(bdq_pkg::REQ_PUSH_BACK, 32'h5A5A_5A5A);
        wait_for_drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 62; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
                default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
            endcase
            // With the sender never idle, a long receiver hold-off backs up the block.
            if (phase == 0)
                rx_hold_reqs++;
            run_random(ITEMS_PER_PHASE);
            wait_for_drain();
        end

        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
